// ===== rtl/core/spwf_pkg.sv =====
// shared types and constants of the staged port word fifo
package spwf_pkg;

  localparam int BUFFER_DEPTH = 8;
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int IDX_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int WORD_W       = 16;
  localparam int KIND_W       = 3;
  localparam int COUNT_OUT_W  = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_RX_PUSH  = 3'd0,
    KIND_TX_PUSH  = 3'd1,
    KIND_POP      = 3'd2,
    KIND_READ_OVF = 3'd3,
    KIND_TICK     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT,
    ST_OUT_FULL
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

// ===== rtl/core/spwf_ctrl.sv =====
// handshake controller: sequences load, execute and result transfer
module spwf_ctrl
  import spwf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        in_take;
  logic        out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    in_stall  = !((state_r == ST_IDLE) || (state_r == ST_OUT));
    out_valid = (state_r == ST_OUT) || (state_r == ST_OUT_FULL);
    in_take   = in_valid && !in_stall;
    out_take  = out_valid && !out_stall;
    cmd.load  = in_take;
    cmd.exec  = (state_r == ST_EXEC);
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // next item may be taken while the result still waits
        if (in_take && out_take)       state_nxt = ST_EXEC;
        else if (in_take)              state_nxt = ST_OUT_FULL;
        else if (out_take)             state_nxt = ST_IDLE;
      end
      ST_OUT_FULL: begin
        if (out_take) state_nxt = ST_EXEC;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_exec_only_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> $past(cmd.load) || $past(state_r == ST_OUT_FULL))
    else $error("execute without a loaded item");

  a_result_held_until_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_no_load_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT_FULL |-> !cmd.load && !cmd.exec)
    else $error("item overwritten while one is pending");

endmodule

// ===== rtl/core/spwf_dpath.sv =====
// datapath: shift-register word store, counts, flags and result register
module spwf_dpath
  import spwf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [WORD_W-1:0]      in_data_word,
  output logic                   out_status,
  output logic [WORD_W-1:0]      out_word_out,
  output logic                   out_advanced,
  output logic                   out_overflow_seen,
  output logic                   out_busy_mark,
  output logic                   out_pending,
  output logic                   out_has_data,
  output logic                   out_has_free,
  output logic [COUNT_OUT_W-1:0] out_held_count,
  output logic [COUNT_OUT_W-1:0] out_ready_count
);

  logic [KIND_W-1:0] kind_r;
  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] words_r [BUFFER_DEPTH];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rel_r, rel_nxt;
  logic              ovf_r, ovf_nxt;
  logic              busy_r, busy_nxt;
  logic              full;
  logic              do_push;
  logic              do_pop;
  logic              res_status;
  logic              res_adv;
  logic              res_ovf_seen;
  logic [IDX_W-1:0]  wr_idx;

  assign full   = (count_r == CNT_W'(BUFFER_DEPTH));
  assign wr_idx = count_r[IDX_W-1:0];

  always_comb begin
    count_nxt    = count_r;
    rel_nxt      = rel_r;
    ovf_nxt      = ovf_r;
    busy_nxt     = busy_r;
    res_status   = 1'b0;
    res_adv      = 1'b0;
    res_ovf_seen = 1'b0;
    do_push      = 1'b0;
    do_pop       = 1'b0;
    case (kind_r)
      KIND_RX_PUSH, KIND_TX_PUSH: begin
        if (!full) begin
          do_push   = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          busy_nxt  = 1'b1;
        end else begin
          res_status = 1'b1;
          // only the receive side records overflow
          if (kind_r == KIND_RX_PUSH) ovf_nxt = 1'b1;
        end
      end
      KIND_POP: begin
        if (rel_r != '0) begin
          do_pop    = 1'b1;
          count_nxt = count_r - CNT_W'(1);
          rel_nxt   = rel_r - CNT_W'(1);
        end else begin
          res_status = 1'b1;
        end
      end
      KIND_READ_OVF: begin
        res_ovf_seen = ovf_r;
        ovf_nxt      = 1'b0;
      end
      KIND_TICK: begin
        if (rel_r < count_r) begin
          rel_nxt  = rel_r + CNT_W'(1);
          busy_nxt = 1'b0;
          res_adv  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      data_r <= in_data_word;
    end
  end

  // word store: append at the back, shift down by one on pop
  always_ff @(posedge clk) begin
    for (int i = 0; i < BUFFER_DEPTH; i++) begin
      if (cmd.exec && do_pop && (i < BUFFER_DEPTH - 1)) begin
        words_r[i] <= words_r[(i < BUFFER_DEPTH - 1) ? i + 1 : i];
      end else if (cmd.exec && do_push && (wr_idx == IDX_W'(i))) begin
        words_r[i] <= data_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rel_r   <= '0;
      ovf_r   <= 1'b0;
      busy_r  <= 1'b0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
      rel_r   <= rel_nxt;
      ovf_r   <= ovf_nxt;
      busy_r  <= busy_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status        <= res_status;
      out_word_out      <= do_pop ? words_r[0] : '0;
      out_advanced      <= res_adv;
      out_overflow_seen <= res_ovf_seen;
      out_busy_mark     <= busy_nxt;
      out_pending       <= (rel_nxt < count_nxt);
      out_has_data      <= (rel_nxt != '0);
      out_has_free      <= (count_nxt != CNT_W'(BUFFER_DEPTH));
      out_held_count    <= COUNT_OUT_W'(count_nxt);
      out_ready_count   <= COUNT_OUT_W'(rel_nxt);
    end
  end

  a_released_within_held: assert property (@(posedge clk) disable iff (!rst_n)
    rel_r <= count_r)
    else $error("released count above held count");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(BUFFER_DEPTH))
    else $error("held count above depth");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && do_pop |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("pop did not remove a word");

endmodule

// ===== rtl/core/staged_port_word_fifo_unit.sv =====
// top level of the staged port word fifo
// Word FIFO of an emulated port: pushes append 16-bit words at the back of an
// eight-entry shift register, process ticks release held words one at a time,
// and a pop takes the front word only once it has been released. Every result
// carries the held and released counts and the status bits after the item.
// From input transfer to the earliest result transfer an item is captured, then
// executed in the datapath's execute state, after which the result register is offered.
// The next item is taken while a result waits; input is stalled only in the
// controller's execute state and while a result and a captured item both wait.
// Reset clears counts and flags synchronously.
module staged_port_word_fifo_unit
  import spwf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [WORD_W-1:0]      in_data_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_status,
  output logic [WORD_W-1:0]      out_word_out,
  output logic                   out_advanced,
  output logic                   out_overflow_seen,
  output logic                   out_busy_mark,
  output logic                   out_pending,
  output logic                   out_has_data,
  output logic                   out_has_free,
  output logic [COUNT_OUT_W-1:0] out_held_count,
  output logic [COUNT_OUT_W-1:0] out_ready_count
);

  dp_cmd_t cmd;

  spwf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  spwf_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_kind           (in_kind),
    .in_data_word      (in_data_word),
    .out_status        (out_status),
    .out_word_out      (out_word_out),
    .out_advanced      (out_advanced),
    .out_overflow_seen (out_overflow_seen),
    .out_busy_mark     (out_busy_mark),
    .out_pending       (out_pending),
    .out_has_data      (out_has_data),
    .out_has_free      (out_has_free),
    .out_held_count    (out_held_count),
    .out_ready_count   (out_ready_count)
  );

endmodule
